// ----- src/btpl_pkg.sv -----
package btpl_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_RECORD_BITS = 2'd0;
	localparam logic [1:0] CFG_TREE_NODES  = 2'd1;
	localparam logic [1:0] CFG_TREE_IS_V6  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_FOUND   = 2'd0;
	localparam logic [1:0] ST_NO_DATA = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_FAIL    = 2'd3;

	// Kind of byte fetched for a record.
	localparam logic [1:0] KIND_HEAD = 2'd0;
	localparam logic [1:0] KIND_FULL = 2'd1;
	localparam logic [1:0] KIND_TAIL = 2'd2;

	localparam int KEY_W  = 128;
	localparam int NODE_W = 32;
	localparam int POS_W  = 39;
	localparam int PTR_W  = 36;
	localparam logic [5:0] MAX_RECORD_BITS = 6'd32;
	localparam logic [5:0] NIBBLE_BITS     = 6'd4;
	localparam logic [32:0] RESERVED_SPAN  = 33'd16;

	typedef struct packed {
		logic wr;
		logic load;
		logic mul;
		logic issue;
		logic fail;
		logic eval;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic pre_fail;
		logic more;
		logic oob;
		logic infl;
		logic eval_done;
	} dp_sts_t;

endpackage

// ----- src/btpl_req_if.sv -----
interface btpl_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic        query_v6;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	logic [17:0] mem_index;
	logic [7:0]  mem_byte;

	modport source (
		output valid, action, query_v6, addr_high, addr_low, mem_index, mem_byte,
		input ready
	);
	modport sink (
		input valid, action, query_v6, addr_high, addr_low, mem_index, mem_byte,
		output ready
	);
endinterface

// ----- src/btpl_rsp_if.sv -----
interface btpl_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] data_offset;

	modport source (
		output valid, status, data_offset,
		input ready
	);
	modport sink (
		input valid, status, data_offset,
		output ready
	);
endinterface

// ----- src/binary_trie_prefix_lookup_unit.sv -----
// Tree memory write words are taken one per cycle while no lookup is in progress and produce no result word.
// A lookup walks L tree levels and fetches B record bytes (1 to 4) for each level through the
// single port of the tree RAM; a result word is given when the walk ends. A full IPv6 walk
// covers 128 levels, IPv4 32. The next word is accepted from the cycle in which the result
// word appears.
// Reset clears control state and sets record size 24, zero nodes and an IPv6 tree;
// the tree RAM is not cleared and is undefined until written.
module binary_trie_prefix_lookup_unit #(
	parameter int MEM_BYTES = 262144
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	btpl_req_if.sink    req,
	btpl_rsp_if.source  rsp
);
	import btpl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	btpl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_action (req.action),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	btpl_dp #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.query_v6    (req.query_v6),
		.addr_high   (req.addr_high),
		.addr_low    (req.addr_low),
		.mem_index   (req.mem_index),
		.mem_byte    (req.mem_byte),
		.cmd         (cmd),
		.sts         (sts),
		.status      (rsp.status),
		.data_offset (rsp.data_offset)
	);

endmodule

// ----- src/btpl_ram.sv -----
module btpl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- src/btpl_ctrl.sv -----
module btpl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_action,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  btpl_pkg::dp_sts_t sts,
	output btpl_pkg::dp_cmd_t cmd
);
	import btpl_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!in_action) begin
						cmd.wr = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = sts.pre_fail ? S_FIN : S_MUL;
					end
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_READ;
			end
			S_READ: begin
				// Byte reads overlap with merging of the previous byte.
				if (sts.more) begin
					if (sts.oob) begin
						cmd.fail = 1'b1;
						state_d  = S_FIN;
					end else begin
						cmd.issue = 1'b1;
					end
				end else if (!sts.infl) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.eval_done ? S_FIN : S_MUL;
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> sts.more && !sts.oob)
		else $error("byte read issued with no byte pending or beyond memory");

	a_eval_settled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> !sts.infl && !sts.more)
		else $error("record evaluated before all of its bytes were merged");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul, cmd.issue, cmd.eval, cmd.fail}))
		else $error("more than one walk step commanded at once");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !out_valid_q || out_ready)
		else $error("result published over a word not yet taken");

endmodule

// ----- src/btpl_dp.sv -----
module btpl_dp #(
	parameter int MEM_BYTES = 262144
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              query_v6,
	input  logic [63:0]       addr_high,
	input  logic [63:0]       addr_low,
	input  logic [17:0]       mem_index,
	input  logic [7:0]        mem_byte,
	input  btpl_pkg::dp_cmd_t cmd,
	output btpl_pkg::dp_sts_t sts,
	output logic [1:0]        status,
	output logic [31:0]       data_offset
);
	import btpl_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);

	// Configuration.
	logic [5:0]        rb_q;
	logic [NODE_W-1:0] tn_q;
	logic              v6_q;

	// Walk state.
	logic [KEY_W-1:0]  key_q;
	logic [NODE_W-1:0] node_q;
	logic [6:0]        lvl_q;
	logic [PTR_W-1:0]  ptr_q;
	logic              head_q;
	logic [2:0]        full_cnt_q;
	logic              tail_q;
	logic [1:0]        kind_q;
	logic              infl_q;
	logic [31:0]       acc_q;
	logic [1:0]        fin_status_q;
	logic [31:0]       fin_off_q;
	logic [1:0]        out_status_q;
	logic [31:0]       out_off_q;

	logic [POS_W-1:0]  bitpos;
	logic              half;
	logic [PTR_W-1:0]  widx;
	logic              wr_ok;
	logic [AW-1:0]     ram_addr;
	logic [7:0]        ram_rdata;
	logic [4:0]        tail_sh;
	logic              hit_nil;
	logic              above;
	logic              invalid;
	logic              last_level;
	logic [31:0]       found_off;
	logic [1:0]        next_kind;

	assign widx     = PTR_W'(mem_index);
	assign wr_ok    = cmd.wr && (widx < PTR_W'(MEM_BYTES));
	assign ram_addr = cmd.wr ? widx[AW-1:0] : ptr_q[AW-1:0];

	btpl_ram #(
		.WIDTH (8),
		.DEPTH (MEM_BYTES)
	) u_tree_ram (
		.clk   (clk),
		.we    (wr_ok),
		.addr  (ram_addr),
		.wdata (mem_byte),
		.rdata (ram_rdata)
	);

	// Bit position of the chosen record: (2 * node + direction) * record size.
	assign bitpos = POS_W'({node_q, key_q[KEY_W-1]}) * POS_W'(rb_q);
	assign half   = bitpos[2];

	assign tail_sh = 5'(rb_q - NIBBLE_BITS);

	assign hit_nil    = (acc_q == tn_q);
	assign above      = (acc_q > tn_q);
	assign invalid    = ({1'b0, acc_q} < ({1'b0, tn_q} + RESERVED_SPAN));
	assign found_off  = acc_q - tn_q - 32'(RESERVED_SPAN);
	assign last_level = (lvl_q == 7'd0);

	always_comb begin
		priority if (head_q) begin
			next_kind = KIND_HEAD;
		end else if (full_cnt_q != 3'd0) begin
			next_kind = KIND_FULL;
		end else begin
			next_kind = KIND_TAIL;
		end
	end

	assign sts.pre_fail  = (tn_q == '0) || (query_v6 && !v6_q) || (rb_q == 6'd0)
		|| (rb_q > MAX_RECORD_BITS) || (rb_q[1:0] != 2'd0);
	assign sts.more      = head_q || (full_cnt_q != 3'd0) || tail_q;
	assign sts.oob       = (ptr_q >= PTR_W'(MEM_BYTES));
	assign sts.infl      = infl_q;
	assign sts.eval_done = hit_nil || above || last_level;

	assign status      = out_status_q;
	assign data_offset = out_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_q   <= 6'd24;
			tn_q   <= '0;
			v6_q   <= 1'b1;
			infl_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RECORD_BITS: rb_q <= cfg_data[5:0];
					CFG_TREE_NODES:  tn_q <= cfg_data;
					CFG_TREE_IS_V6:  v6_q <= cfg_data[0];
					default: ;
				endcase
			end
			infl_q <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q <= '0;
			if (v6_q) begin
				key_q <= query_v6 ? {addr_high, addr_low} : {96'd0, addr_low[31:0]};
				lvl_q <= 7'd127;
			end else begin
				// A 32-bit tree walks the IPv4 bits from the top of the key.
				key_q <= {addr_low[31:0], 96'd0};
				lvl_q <= 7'd31;
			end
			if (sts.pre_fail) begin
				fin_status_q <= ST_FAIL;
				fin_off_q    <= '0;
			end
		end

		if (cmd.mul) begin
			ptr_q      <= bitpos[POS_W-1:3];
			head_q     <= half;
			full_cnt_q <= half ? 3'((rb_q - NIBBLE_BITS) >> 3) : 3'(rb_q >> 3);
			tail_q     <= rb_q[2] && !half;
			acc_q      <= '0;
		end

		if (cmd.issue) begin
			ptr_q  <= ptr_q + PTR_W'(1);
			kind_q <= next_kind;
			unique case (next_kind)
				KIND_HEAD: head_q     <= 1'b0;
				KIND_FULL: full_cnt_q <= full_cnt_q - 3'd1;
				KIND_TAIL: tail_q     <= 1'b0;
				default: ;
			endcase
		end

		if (infl_q) begin
			unique case (kind_q)
				KIND_HEAD: acc_q <= {28'd0, ram_rdata[3:0]};
				KIND_FULL: acc_q <= {acc_q[23:0], ram_rdata};
				KIND_TAIL: acc_q <= acc_q | (32'(ram_rdata[7:4]) << tail_sh);
				default: ;
			endcase
		end

		if (cmd.fail) begin
			fin_status_q <= ST_FAIL;
			fin_off_q    <= '0;
		end

		if (cmd.eval) begin
			priority if (hit_nil) begin
				fin_status_q <= ST_NO_DATA;
				fin_off_q    <= '0;
			end else if (above) begin
				fin_status_q <= invalid ? ST_INVALID : ST_FOUND;
				fin_off_q    <= invalid ? 32'd0 : found_off;
			end else if (last_level) begin
				fin_status_q <= ST_NO_DATA;
				fin_off_q    <= '0;
			end else begin
				node_q <= acc_q;
				key_q  <= {key_q[KEY_W-2:0], 1'b0};
				lvl_q  <= lvl_q - 7'd1;
			end
		end

		if (cmd.publish) begin
			out_status_q <= fin_status_q;
			out_off_q    <= fin_off_q;
		end
	end

endmodule
